// ----- src/frc_pkg.sv -----
// ----------------------------------------------------------------------------
// frc_pkg
// shared types, constants and the byte-wide crc-32 update of the record checker
// ----------------------------------------------------------------------------
`default_nettype none

package frc_pkg;

    localparam logic [10:0] MAX_PAYLOAD   = 11'd1024;
    localparam logic [10:0] COUNT_MAX     = 11'd2047;
    localparam logic [10:0] MIN_RECORD    = 11'd16;
    localparam logic [3:0]  HEADER_BYTES  = 4'd12;
    localparam logic [2:0]  TRAILER_BYTES = 3'd4;
    localparam logic [31:0] CRC_POLY      = 32'hedb88320;
    localparam logic [31:0] CRC_ALL_ONES  = 32'hffffffff;

    typedef enum logic [1:0] {
        REG_MAGIC_WORD      = 2'd0,
        REG_SCHEMA_CUR      = 2'd1,
        REG_PAYLOAD_LIMIT   = 2'd2,
        REG_EXCLUDED_PREFIX = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        STATUS_VALID            = 2'd0,
        STATUS_CORRUPT          = 2'd1,
        STATUS_UNSUPPORTED      = 2'd2,
        STATUS_MIGRATION_FAILED = 2'd3
    } status_t;

    typedef struct packed {
        logic [31:0] magic_word;
        logic [7:0]  schema_cur;
        logic [10:0] payload_limit;
        logic [10:0] excluded_prefix;
    } cfg_t;

    typedef struct packed {
        logic        magic_match;
        logic [7:0]  version_byte;
        logic [7:0]  reserved_byte;
        logic [15:0] length_field;
        logic [31:0] generation_field;
        logic [31:0] crc_accumulator;
        logic [31:0] tail_delay;
    } rec_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- src/frc_verdict.sv -----
// ----------------------------------------------------------------------------
// frc_verdict
// checks a finished record in priority order and forms the result fields
// ----------------------------------------------------------------------------
`default_nettype none

module frc_verdict
    import frc_pkg::*;
(
    input  wire cfg_t        cfg,
    input  wire rec_t        rec,
    input  wire [10:0]       count,      // bytes before the last one
    input  wire              accepted,
    output status_t          status,
    output logic [31:0]      generation,
    output logic [10:0]      payload_length
);

    logic [10:0] cap;
    logic [10:0] room;
    logic [10:0] size;
    logic [16:0] payload;
    logic [16:0] total;
    logic        crc_ok;

    always_comb begin
        if (cfg.payload_limit == 11'd0 || cfg.payload_limit > MAX_PAYLOAD) begin
            cap = MAX_PAYLOAD;
        end else begin
            cap = cfg.payload_limit;
        end
        room    = cap - cfg.excluded_prefix;
        size    = count + 11'd1;
        payload = {1'b0, rec.length_field} + {6'd0, cfg.excluded_prefix};
        total   = payload + {13'd0, HEADER_BYTES} + {14'd0, TRAILER_BYTES};
        crc_ok  = (rec.tail_delay == (rec.crc_accumulator ^ CRC_ALL_ONES));

        if (count == COUNT_MAX) begin
            status = STATUS_CORRUPT;
        end else if (size < MIN_RECORD || !rec.magic_match) begin
            status = STATUS_CORRUPT;
        end else if (rec.version_byte > cfg.schema_cur) begin
            status = STATUS_UNSUPPORTED;
        end else if (rec.version_byte < cfg.schema_cur) begin
            status = STATUS_MIGRATION_FAILED;
        end else if (cfg.excluded_prefix > cap
                     || rec.length_field > {5'd0, room}) begin
            status = STATUS_CORRUPT;
        end else if (rec.reserved_byte != 8'd0 || payload == 17'd0
                     || payload > {6'd0, cap} || total != {6'd0, size}
                     || rec.generation_field == 32'd0 || !crc_ok || !accepted) begin
            status = STATUS_CORRUPT;
        end else begin
            status = STATUS_VALID;
        end

        if (status == STATUS_VALID) begin
            generation     = rec.generation_field;
            payload_length = payload[10:0];
        end else begin
            generation     = 32'd0;
            payload_length = 11'd0;
        end
    end

endmodule

`default_nettype wire

// ----- src/framed_record_checker.sv -----
// ----------------------------------------------------------------------------
// framed_record_checker
// validates a framed record taken one byte per item and gives one verdict per record
// ----------------------------------------------------------------------------
//  channel  direction  tdata                                   tlast      tuser
//  s_       in         [7:0] data_byte                         last_byte  payload_accepted
//  m_       out        [1:0] status, [33:2] generation,        -          -
//                      [44:34] payload_length, [47:45] zero
//  cfg_wr_  in         index 0 magic, 1 schema, 2 capacity, 3 prefix
//
//  one byte per cycle while s_tready is high; header capture, crc update and
//  the verdict sit between the record state registers and the result register
//  only the byte marked last gives a result, in the cycle after it is accepted
//  s_tready drops only while a result waits and m_tready is low
//  reset is synchronous on aresetn, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module framed_record_checker
    import frc_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,

    input  wire         cfg_wr_en,
    input  wire  [1:0]  cfg_wr_index,
    input  wire  [31:0] cfg_wr_data,

    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,     // data_byte
    input  wire         s_tlast,
    input  wire         s_tuser,     // payload_accepted

    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [47:0] m_tdata      // status, generation, payload_length, zero fill
);

    cfg_t        cfg_reg;
    rec_t        rec_reg, rec_next;
    logic [10:0] count_reg, count_next;

    logic        m_valid_reg;
    logic [44:0] m_data_reg;

    logic        accept;
    status_t     status;
    logic [31:0] generation;
    logic [10:0] payload_length;
    logic [7:0]  magic_byte;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'd0, m_data_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.magic_word      <= 32'd0;
            cfg_reg.schema_cur      <= 8'd1;
            cfg_reg.payload_limit   <= MAX_PAYLOAD;
            cfg_reg.excluded_prefix <= 11'd0;
        end else if (cfg_wr_en) begin
            unique case (reg_index_t'(cfg_wr_index))
                REG_MAGIC_WORD:      cfg_reg.magic_word      <= cfg_wr_data;
                REG_SCHEMA_CUR:      cfg_reg.schema_cur      <= cfg_wr_data[7:0];
                REG_PAYLOAD_LIMIT:   cfg_reg.payload_limit   <= cfg_wr_data[10:0];
                REG_EXCLUDED_PREFIX: cfg_reg.excluded_prefix <= cfg_wr_data[10:0];
                default:             cfg_reg.magic_word      <= cfg_reg.magic_word;
            endcase
        end
    end

    always_comb begin
        magic_byte = cfg_reg.magic_word[8*count_reg[1:0] +: 8];
        rec_next   = rec_reg;

        if (count_reg < 11'd4) begin
            if (s_tdata != magic_byte) begin
                rec_next.magic_match = 1'b0;
            end
        end else if (count_reg == 11'd4) begin
            rec_next.version_byte = s_tdata;
        end else if (count_reg == 11'd5) begin
            rec_next.reserved_byte = s_tdata;
        end else if (count_reg == 11'd6) begin
            rec_next.length_field[7:0] = s_tdata;
        end else if (count_reg == 11'd7) begin
            rec_next.length_field[15:8] = s_tdata;
        end else if (count_reg < {7'd0, HEADER_BYTES}) begin
            rec_next.generation_field[8*count_reg[1:0] +: 8] = s_tdata;
        end

        if (count_reg >= {8'd0, TRAILER_BYTES}) begin
            rec_next.crc_accumulator = crc_byte(rec_reg.crc_accumulator,
                                                rec_reg.tail_delay[7:0]);
        end
        rec_next.tail_delay = {s_tdata, rec_reg.tail_delay[31:8]};

        if (count_reg != COUNT_MAX) begin
            count_next = count_reg + 11'd1;
        end else begin
            count_next = COUNT_MAX;
        end
    end

    frc_verdict u_verdict (
        .cfg            (cfg_reg),
        .rec            (rec_next),
        .count          (count_reg),
        .accepted       (s_tuser),
        .status         (status),
        .generation     (generation),
        .payload_length (payload_length)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg                <= 11'd0;
            rec_reg.magic_match      <= 1'b1;
            rec_reg.version_byte     <= 8'd0;
            rec_reg.reserved_byte    <= 8'd0;
            rec_reg.length_field     <= 16'd0;
            rec_reg.generation_field <= 32'd0;
            rec_reg.crc_accumulator  <= CRC_ALL_ONES;
            rec_reg.tail_delay       <= 32'd0;
            m_valid_reg              <= 1'b0;
        end else begin
            if (accept) begin
                if (s_tlast) begin
                    count_reg                <= 11'd0;
                    rec_reg.magic_match      <= 1'b1;
                    rec_reg.version_byte     <= 8'd0;
                    rec_reg.reserved_byte    <= 8'd0;
                    rec_reg.length_field     <= 16'd0;
                    rec_reg.generation_field <= 32'd0;
                    rec_reg.crc_accumulator  <= CRC_ALL_ONES;
                    rec_reg.tail_delay       <= 32'd0;
                end else begin
                    count_reg <= count_next;
                    rec_reg   <= rec_next;
                end
            end

            if (accept && s_tlast) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_tlast) begin
            m_data_reg <= {payload_length, generation, status};
        end
    end

endmodule

`default_nettype wire
